@@ design/jvrg_pkg.sv @@
// shared types and constants for the jog velocity ramp generator
// transfer structs, controller/datapath command and status, state codes
package jvrg_pkg;

    // fixed-point widths
    localparam int VEL_W  = 32;   // Q24.8 velocity and acceleration
    localparam int POS_W  = 48;   // Q32.16 command position
    localparam int DT_W   = 24;   // Q0.24 tick length
    localparam int DV_W   = 33;   // rounded velocity step
    localparam int INC_W  = 52;   // position increment accumulator
    localparam int MUL_W  = 33;   // multiplier operand width
    localparam int PROD_W = 66;   // multiplier product width
    localparam int DIV_N  = 71;   // divider dividend and quotient width
    localparam int DIV_D  = 33;   // divider divisor width
    localparam int DIV_CW = 7;    // divider step counter width

    // configuration register indexes
    localparam logic [1:0] CFG_JOG_SPEED   = 2'd0;
    localparam logic [1:0] CFG_JOG_ACCEL   = 2'd1;
    localparam logic [1:0] CFG_TICK_PERIOD = 2'd2;

    // configuration reset values
    localparam logic [VEL_W-1:0] JOG_ACCEL_RST   = 32'd256;
    localparam logic [DT_W-1:0]  TICK_PERIOD_RST = 24'd16777;

    // item operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    typedef enum logic [1:0] {
        MOTION_IDLE     = 2'd0,
        MOTION_JOG      = 2'd1,
        MOTION_STOPPING = 2'd2
    } t_mode;

    typedef enum logic [4:0] {
        ST_IDLE, ST_EXEC, ST_C1, ST_C2, ST_C3,
        ST_A1, ST_A2, ST_M1, ST_M2, ST_M3, ST_FIN_M,
        ST_Q0, ST_QW, ST_Q1, ST_Q2, ST_Q3, ST_Q4, ST_FIN_S,
        ST_VV, ST_SD, ST_SW, ST_S1, ST_FIN_Z, ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        MUL_NONE, MUL_ADT, MUL_DTDT, MUL_SDT, MUL_VDT,
        MUL_ADT2, MUL_SVQ, MUL_SDTQ, MUL_VV
    } t_mul_sel;

    typedef enum logic [2:0] {
        INC_HOLD, INC_CLR, INC_LD16, INC_LD17,
        INC_ADD16, INC_ADD17, INC_SUB17, INC_STOP
    } t_inc_op;

    typedef enum logic [1:0] {
        POS_HOLD, POS_ADD, POS_LOAD
    } t_pos_op;

    typedef enum logic [2:0] {
        VEL_HOLD, VEL_ZERO, VEL_S, VEL_ADD_DV, VEL_SUB_DV
    } t_vel_op;

    typedef enum logic {
        DIV_Q, DIV_STOP
    } t_div_sel;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [31:0]      load_pos;
        logic                    limit_left;
        logic                    limit_right;
        logic                    stop_request;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]      target_pos;
        logic signed [31:0]      speed_now;
        logic [1:0]              motion_mode;
    } t_out_item;

    typedef struct packed {
        logic     ld_item;
        logic     ld_out;
        t_mul_sel mul_sel;
        logic     ld_dv;
        logic     ld_dt2;
        t_inc_op  inc_op;
        t_pos_op  pos_op;
        t_vel_op  vel_op;
        logic     div_start;
        t_div_sel div_sel;
        logic     ld_q;
    } t_dp_cmd;

    typedef struct packed {
        logic s_pos;
        logic s_neg;
        logic a_zero;
        logic v_ge_s;
        logic vpd_gt_s;
        logic decel_stop;
        logic div_busy;
    } t_dp_stat;

endpackage

@@ design/jog_velocity_ramp_generator.sv @@
// top level of the single-axis jog velocity ramp generator
// depends on jvrg_pkg, jvrg_ctrl, jvrg_dp (and jvrg_div below it)
//
// Usage:
// - input channel (i_in_valid / o_in_stall / i_in_data): one item per
//   transfer; op is tick, start jog, load position or no-op
// - output channel (o_out_valid / i_out_stall / o_out_data): exactly one
//   result per item, giving position in whole counts, velocity and mode
// - config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   index 0 jog speed, 1 jog acceleration, 2 tick period; always ready,
//   write only while no item is in flight
// - one item is worked on at a time; start jog, load, no-op, idle tick or
//   limit stop go straight from transfer to result; ticks at jog speed,
//   ramp or braking steps and stops with zero acceleration take the
//   multiplier path; a tick that reaches speed and one that computes a
//   stopping distance also wait on the 71-step shared divider
// - a result waits in the output register while the receiver stalls; the
//   next item is taken meanwhile, and its result is held back until the
//   register is free
// - reset clears mode to idle, velocity and position to zero and the
//   config registers to their defaults
module jog_velocity_ramp_generator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  jvrg_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output jvrg_pkg::t_out_item   o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);
    import jvrg_pkg::*;

    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    logic [1:0]         w_mode;
    logic signed [31:0] w_pos;
    logic signed [31:0] w_speed;

    assign o_cfg_ready = 1'b1;

    // sequencing
    jvrg_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_item        (i_in_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_motion_mode (w_mode),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd)
    );

    // arithmetic and state
    jvrg_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_item       (i_in_data),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_stat       (w_stat),
        .o_target_pos (w_pos),
        .o_speed_now  (w_speed)
    );

    // result transfer payload
    assign o_out_data.target_pos  = w_pos;
    assign o_out_data.speed_now   = w_speed;
    assign o_out_data.motion_mode = w_mode;

`ifndef SYNTH
    // one item at a time: a transfer closes the input
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while an item is in flight");

    // the divider is never restarted while running
    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !w_stat.div_busy)
        else $error("divider started while busy");

    // a held result is never overwritten
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ld_out |-> !(o_out_valid && i_out_stall))
        else $error("result register loaded while stalled");
`endif

endmodule

@@ design/jvrg_div.sv @@
// unsigned restoring divider, one quotient bit per cycle
// depends on jvrg_pkg for widths
module jvrg_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [jvrg_pkg::DIV_N-1:0]    i_dividend,
    input  logic [jvrg_pkg::DIV_D-1:0]    i_divisor,
    output logic                          o_busy,
    output logic [jvrg_pkg::DIV_N-1:0]    o_quotient
);
    import jvrg_pkg::*;

    logic [DIV_D-1:0]  r_rem;
    logic [DIV_N-1:0]  r_quo;
    logic [DIV_D-1:0]  r_div;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;

    logic [DIV_D:0]    rem_sh;
    logic              ge;
    logic [DIV_D:0]    rem_sub;
    logic [DIV_D-1:0]  n_rem;

    // trial subtract of the shifted remainder
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_N-1]};
        ge      = (rem_sh >= {1'b0, r_div});
        rem_sub = rem_sh - {1'b0, r_div};
        n_rem   = ge ? rem_sub[DIV_D-1:0] : rem_sh[DIV_D-1:0];
    end

    // control: step counter and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CW'(DIV_N);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath: remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_N-2:0], ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

@@ design/jvrg_dp.sv @@
// datapath: configuration, velocity and position state, shared multiplier
// depends on jvrg_pkg and jvrg_div
module jvrg_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  jvrg_pkg::t_dp_cmd     i_cmd,
    input  jvrg_pkg::t_in_item    i_item,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    output jvrg_pkg::t_dp_stat    o_stat,
    output logic signed [31:0]    o_target_pos,
    output logic signed [31:0]    o_speed_now
);
    import jvrg_pkg::*;

    localparam logic [POS_W-1:0]    POS_MAX    = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0]    POS_MIN    = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [DIV_N-9:0]    STOP_Q_CAP = (DIV_N-8)'(1) << 40;
    localparam logic [INC_W-1:0]    STOP_CAP   = INC_W'(1) << 50;

    logic signed [VEL_W-1:0] r_speed;
    logic signed [VEL_W-1:0] r_accel;
    logic [DT_W-1:0]         r_tick;
    logic signed [VEL_W-1:0] r_vel;
    logic signed [POS_W-1:0] r_pos;
    logic signed [31:0]      r_load_pos;
    logic signed [DV_W-1:0]  r_dv;
    logic [DT_W-1:0]         r_dt2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [INC_W-1:0] r_inc;
    logic [DT_W-1:0]         r_q;
    logic signed [31:0]      r_out_pos;
    logic signed [31:0]      r_out_speed;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] p24;
    logic signed [PROD_W-1:0] p16;
    logic signed [PROD_W-1:0] p17;

    logic signed [32:0] v_ext;
    logic signed [32:0] s_ext;
    logic signed [32:0] a_ext;
    logic signed [32:0] sv_sum;
    logic signed [32:0] sv_diff;
    logic [32:0]        abs_v;
    logic [32:0]        abs_s;
    logic [32:0]        abs_a;
    logic [32:0]        abs_d;
    logic signed [33:0] vpd;
    logic signed [33:0] nv;
    logic [33:0]        abs_vpd;

    logic [DIV_N-1:0]   div_dividend;
    logic [DIV_D-1:0]   div_divisor;
    logic               div_busy;
    logic [DIV_N-1:0]   div_quo;

    logic [INC_W-1:0]   stop_mag;
    logic [INC_W-1:0]   stop_inc;
    logic [DT_W-1:0]    q_clamped;
    logic signed [INC_W:0] pos_sum;
    logic [POS_W-1:0]   n_pos;
    logic [VEL_W-1:0]   vel_add;
    logic [VEL_W-1:0]   vel_sub;
    logic [POS_W-1:0]   tp_sum;
    logic [INC_W-1:0]   n_inc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
            r_accel <= JOG_ACCEL_RST;
            r_tick  <= TICK_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_JOG_SPEED:   r_speed <= i_cfg_data;
                CFG_JOG_ACCEL:   r_accel <= i_cfg_data;
                CFG_TICK_PERIOD: r_tick  <= i_cfg_data[DT_W-1:0];
                default: ;
            endcase
        end
    end

    // sign-extended operands and magnitudes
    always_comb begin
        v_ext   = {r_vel[VEL_W-1], r_vel};
        s_ext   = {r_speed[VEL_W-1], r_speed};
        a_ext   = {r_accel[VEL_W-1], r_accel};
        sv_sum  = s_ext + v_ext;
        sv_diff = s_ext - v_ext;
        abs_v   = v_ext[32] ? 33'(-v_ext) : v_ext;
        abs_s   = s_ext[32] ? 33'(-s_ext) : s_ext;
        abs_a   = a_ext[32] ? 33'(-a_ext) : a_ext;
        abs_d   = sv_diff[32] ? 33'(-sv_diff) : sv_diff;
        vpd     = {v_ext[32], v_ext} + {r_dv[DV_W-1], r_dv};
        nv      = {v_ext[32], v_ext} - {r_dv[DV_W-1], r_dv};
        abs_vpd = vpd[33] ? 34'(-vpd) : vpd;
    end

    // status towards the controller
    always_comb begin
        o_stat.s_pos      = !r_speed[VEL_W-1] && (r_speed != '0);
        o_stat.s_neg      = r_speed[VEL_W-1];
        o_stat.a_zero     = (r_accel == '0);
        o_stat.v_ge_s     = (abs_v >= abs_s);
        o_stat.vpd_gt_s   = (abs_vpd > {1'b0, abs_s});
        o_stat.decel_stop = (o_stat.s_pos && nv[33]) ||
                            (o_stat.s_neg && !nv[33] && (nv != '0));
        o_stat.div_busy   = div_busy;
    end

    // shared multiplier operand selection
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_ADT:  begin mul_a = a_ext;          mul_b = {9'b0, r_tick}; end
            MUL_DTDT: begin mul_a = {9'b0, r_tick}; mul_b = {9'b0, r_tick}; end
            MUL_SDT:  begin mul_a = s_ext;          mul_b = {9'b0, r_tick}; end
            MUL_VDT:  begin mul_a = v_ext;          mul_b = {9'b0, r_tick}; end
            MUL_ADT2: begin mul_a = a_ext;          mul_b = {9'b0, r_dt2};  end
            MUL_SVQ:  begin mul_a = sv_sum;         mul_b = {9'b0, r_q};    end
            MUL_SDTQ: begin mul_a = s_ext;          mul_b = {9'b0, r_tick - r_q}; end
            MUL_VV:   begin mul_a = v_ext;          mul_b = v_ext;          end
            default:  begin mul_a = '0;             mul_b = '0;             end
        endcase
        mul_p = mul_a * mul_b;
    end

    // round half up back to format
    always_comb begin
        p24 = (r_prod + 66'sd8388608) >>> 24;
        p16 = (r_prod + 66'sd32768) >>> 16;
        p17 = (r_prod + 66'sd65536) >>> 17;
    end

    // divider operands: time to reach speed, or stopping distance
    always_comb begin
        if (i_cmd.div_sel == DIV_STOP) begin
            div_dividend = {r_prod[62:0], 8'b0};
            div_divisor  = {abs_a[31:0], 1'b0};
        end else begin
            div_dividend = {14'b0, abs_d, 24'b0};
            div_divisor  = abs_a;
        end
    end

    jvrg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    // quotient post-processing
    always_comb begin
        stop_mag = (div_quo[DIV_N-1:8] > STOP_Q_CAP) ? STOP_CAP : div_quo[INC_W-1:0];
        stop_inc = r_accel[VEL_W-1] ? INC_W'(-stop_mag) : stop_mag;
        if (sv_diff[32] ^ r_accel[VEL_W-1]) begin
            q_clamped = '0;
        end else if (div_quo > {{(DIV_N-DT_W){1'b0}}, r_tick}) begin
            q_clamped = r_tick;
        end else begin
            q_clamped = div_quo[DT_W-1:0];
        end
    end

    // increment accumulator next value
    always_comb begin
        unique case (i_cmd.inc_op)
            INC_HOLD:  n_inc = r_inc;
            INC_CLR:   n_inc = '0;
            INC_LD16:  n_inc = p16[INC_W-1:0];
            INC_LD17:  n_inc = p17[INC_W-1:0];
            INC_ADD16: n_inc = r_inc + p16[INC_W-1:0];
            INC_ADD17: n_inc = r_inc + p17[INC_W-1:0];
            INC_SUB17: n_inc = r_inc - p17[INC_W-1:0];
            INC_STOP:  n_inc = stop_inc;
        endcase
    end

    // saturating position and velocity updates
    always_comb begin
        pos_sum = {{(INC_W-POS_W+1){r_pos[POS_W-1]}}, r_pos} + {r_inc[INC_W-1], r_inc};
        if (pos_sum[INC_W:POS_W-1] == {(INC_W-POS_W+2){pos_sum[INC_W]}}) begin
            n_pos = pos_sum[POS_W-1:0];
        end else begin
            n_pos = pos_sum[INC_W] ? POS_MIN : POS_MAX;
        end
        if (vpd[33:31] == {3{vpd[33]}}) begin
            vel_add = vpd[31:0];
        end else begin
            vel_add = vpd[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        if (nv[33:31] == {3{nv[33]}}) begin
            vel_sub = nv[31:0];
        end else begin
            vel_sub = nv[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        tp_sum = r_pos + {{(POS_W-16){1'b0}}, {16{r_pos[POS_W-1]}}};
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel <= '0;
            r_pos <= '0;
        end else begin
            unique case (i_cmd.pos_op)
                POS_ADD:  r_pos <= n_pos;
                POS_LOAD: r_pos <= {r_load_pos, 16'b0};
                default: ;
            endcase
            unique case (i_cmd.vel_op)
                VEL_ZERO:   r_vel <= '0;
                VEL_S:      r_vel <= r_speed;
                VEL_ADD_DV: r_vel <= vel_add;
                VEL_SUB_DV: r_vel <= vel_sub;
                default: ;
            endcase
        end
    end

    // working registers and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_load_pos <= i_item.load_pos;
        end
        if (i_cmd.mul_sel != MUL_NONE) begin
            r_prod <= mul_p;
        end
        if (i_cmd.ld_dv) begin
            r_dv <= p24[DV_W-1:0];
        end
        if (i_cmd.ld_dt2) begin
            r_dt2 <= p24[DT_W-1:0];
        end
        if (i_cmd.ld_q) begin
            r_q <= q_clamped;
        end
        r_inc <= n_inc;
        if (i_cmd.ld_out) begin
            r_out_pos   <= tp_sum[POS_W-1:16];
            r_out_speed <= r_vel;
        end
    end

    assign o_target_pos = r_out_pos;
    assign o_speed_now  = r_out_speed;

endmodule

@@ design/jvrg_ctrl.sv @@
// controller: item sequencing, motion mode and result handshake
// depends on jvrg_pkg; drives the datapath command struct
module jvrg_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  jvrg_pkg::t_in_item    i_item,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [1:0]            o_motion_mode,
    input  jvrg_pkg::t_dp_stat    i_stat,
    output jvrg_pkg::t_dp_cmd     o_cmd
);
    import jvrg_pkg::*;

    t_state     r_state;
    t_state     n_state;
    t_mode      r_mode;
    t_mode      n_mode;
    logic       r_decel;
    logic       n_decel;
    logic [1:0] r_op;
    logic       r_ll;
    logic       r_lr;
    logic       r_stop;
    logic       r_out_valid;
    t_mode      r_out_mode;

    logic accept;
    logic out_free;
    logic limit_hit;
    logic moving;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign limit_hit  = (r_ll && i_stat.s_neg) || (r_lr && i_stat.s_pos);
    assign moving     = ((r_mode == MOTION_JOG) && !limit_hit) || (r_mode == MOTION_STOPPING);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept) n_state = ST_EXEC;
            ST_EXEC:  n_state = ((r_op == OP_TICK) && moving) ? ST_C1 : ST_DONE;
            ST_C1:    n_state = ST_C2;
            ST_C2:    n_state = ST_C3;
            ST_C3: begin
                priority if (r_decel && i_stat.decel_stop) begin
                    n_state = i_stat.a_zero ? ST_FIN_Z : ST_VV;
                end else if (r_decel) begin
                    n_state = ST_M1;
                end else if (i_stat.v_ge_s) begin
                    n_state = ST_A1;
                end else if (i_stat.vpd_gt_s && !i_stat.a_zero) begin
                    n_state = ST_Q0;
                end else begin
                    n_state = ST_M1;
                end
            end
            ST_A1:    n_state = ST_A2;
            ST_A2:    n_state = ST_FIN_S;
            ST_M1:    n_state = ST_M2;
            ST_M2:    n_state = ST_M3;
            ST_M3:    n_state = ST_FIN_M;
            ST_FIN_M: n_state = ST_DONE;
            ST_Q0:    n_state = ST_QW;
            ST_QW:    if (!i_stat.div_busy) n_state = ST_Q1;
            ST_Q1:    n_state = ST_Q2;
            ST_Q2:    n_state = ST_Q3;
            ST_Q3:    n_state = ST_Q4;
            ST_Q4:    n_state = ST_FIN_S;
            ST_FIN_S: n_state = ST_DONE;
            ST_VV:    n_state = ST_SD;
            ST_SD:    n_state = ST_SW;
            ST_SW:    if (!i_stat.div_busy) n_state = ST_S1;
            ST_S1:    n_state = ST_FIN_Z;
            ST_FIN_Z: n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath commands and mode updates
    always_comb begin
        o_cmd.ld_item   = accept;
        o_cmd.ld_out    = 1'b0;
        o_cmd.mul_sel   = MUL_NONE;
        o_cmd.ld_dv     = 1'b0;
        o_cmd.ld_dt2    = 1'b0;
        o_cmd.inc_op    = INC_HOLD;
        o_cmd.pos_op    = POS_HOLD;
        o_cmd.vel_op    = VEL_HOLD;
        o_cmd.div_start = 1'b0;
        o_cmd.div_sel   = DIV_Q;
        o_cmd.ld_q      = 1'b0;
        n_mode          = r_mode;
        n_decel         = r_decel;
        unique case (r_state)
            ST_EXEC: begin
                unique case (r_op)
                    OP_TICK: begin
                        n_decel = (r_mode == MOTION_STOPPING) ||
                                  ((r_mode == MOTION_JOG) && r_stop);
                        if (r_mode == MOTION_JOG) begin
                            if (limit_hit) n_mode = MOTION_IDLE;
                        end else if (r_mode != MOTION_STOPPING) begin
                            o_cmd.vel_op = VEL_ZERO;
                            n_mode       = MOTION_IDLE;
                        end
                    end
                    OP_START: n_mode = MOTION_JOG;
                    OP_LOAD:  o_cmd.pos_op = POS_LOAD;
                    OP_NOP: ;
                endcase
            end
            ST_C1: o_cmd.mul_sel = MUL_ADT;
            ST_C2: begin
                o_cmd.ld_dv   = 1'b1;
                o_cmd.mul_sel = MUL_DTDT;
            end
            ST_C3: begin
                o_cmd.ld_dt2 = 1'b1;
                // stop with zero acceleration moves nothing
                if (r_decel && i_stat.decel_stop && i_stat.a_zero) o_cmd.inc_op = INC_CLR;
            end
            ST_A1: o_cmd.mul_sel = MUL_SDT;
            ST_A2: o_cmd.inc_op  = INC_LD16;
            ST_M1: o_cmd.mul_sel = MUL_VDT;
            ST_M2: begin
                o_cmd.inc_op  = INC_LD16;
                o_cmd.mul_sel = MUL_ADT2;
            end
            ST_M3: o_cmd.inc_op = r_decel ? INC_SUB17 : INC_ADD17;
            ST_FIN_M: begin
                o_cmd.pos_op = POS_ADD;
                o_cmd.vel_op = r_decel ? VEL_SUB_DV : VEL_ADD_DV;
                if (r_decel) n_mode = MOTION_STOPPING;
            end
            ST_Q0: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_Q;
            end
            ST_Q1: o_cmd.ld_q    = 1'b1;
            ST_Q2: o_cmd.mul_sel = MUL_SVQ;
            ST_Q3: begin
                o_cmd.inc_op  = INC_LD17;
                o_cmd.mul_sel = MUL_SDTQ;
            end
            ST_Q4: o_cmd.inc_op = INC_ADD16;
            ST_FIN_S: begin
                o_cmd.pos_op = POS_ADD;
                o_cmd.vel_op = VEL_S;
            end
            ST_VV: o_cmd.mul_sel = MUL_VV;
            ST_SD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_STOP;
            end
            ST_S1: o_cmd.inc_op = INC_STOP;
            ST_FIN_Z: begin
                o_cmd.pos_op = POS_ADD;
                o_cmd.vel_op = VEL_ZERO;
                n_mode       = (r_mode == MOTION_JOG) ? MOTION_STOPPING : MOTION_IDLE;
            end
            ST_DONE: o_cmd.ld_out = out_free;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MOTION_IDLE;
            r_decel     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_decel <= n_decel;
            if (o_cmd.ld_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // captured item flags and result mode
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_item.op;
            r_ll   <= i_item.limit_left;
            r_lr   <= i_item.limit_right;
            r_stop <= i_item.stop_request;
        end
        if (o_cmd.ld_out) begin
            r_out_mode <= r_mode;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_motion_mode = r_out_mode;

endmodule
